FILE: hdl/fpe_pkg.sv
// Shared constants for the frustum plane extraction block.
package fpe_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int EPS_LOG2 = 23;
	localparam int ELEM_W = 32;
	localparam int IDX_W = 2;
	localparam int PLANE_W = 3;
	localparam int ADDR_W = 4;
	localparam int DEPTH = 16;
	localparam logic [PLANE_W-1:0] LAST_PLANE = 3'd5;

endpackage

FILE: hdl/fpe_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/frustum_plane_extract_core.sv
// Top level: matrix load, clip plane sums, bit-serial square, root and divide.
//
// Usage: when idle the host loads matrix elements with start, one transfer
// per cycle, addressed by outer_index and inner_index. busy stays low
// while loading. A transfer with last_element set stores its element and
// then starts the plane run; busy is high until the sixth plane has been
// shown. Every entry must be written at least once before the first run.
// Planes come out in the order left, right, bottom, top, near, far, each on
// the result ports for one cycle marked by result_valid; last_plane marks
// the sixth. The receiver cannot stall the block and must take each result.
// Per plane: read and combine the matrix column pairs, form the squared
// length with a shift-add multiply per component, take the digit-by-digit
// square root and run the four restoring divisions, one bit per cycle,
// then show the result. A plane whose squared length is below the
// threshold (zero with FRACTION_BITS = 16) skips root and divide.
// Reset (arst_n low) returns the sequencer to idle; matrix contents are
// undefined until written.
module frustum_plane_extract_core #(
	parameter int FRACTION_BITS = fpe_pkg::FRACTION_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [fpe_pkg::IDX_W-1:0]             outer_index,
	input  logic [fpe_pkg::IDX_W-1:0]             inner_index,
	input  logic signed [fpe_pkg::ELEM_W-1:0]     element_value,
	input  logic                                  last_element,
	output logic                                  result_valid,
	output logic [fpe_pkg::PLANE_W-1:0]           plane_index,
	output logic signed [fpe_pkg::ELEM_W-1:0]     plane_a,
	output logic signed [fpe_pkg::ELEM_W-1:0]     plane_b,
	output logic signed [fpe_pkg::ELEM_W-1:0]     plane_c,
	output logic signed [fpe_pkg::ELEM_W-1:0]     plane_d,
	output logic                                  was_normalized,
	output logic                                  last_plane
);

	localparam int NW = FRACTION_BITS + 34;
	localparam int CW = $clog2(NW);
	localparam int TSH = (FRACTION_BITS > fpe_pkg::EPS_LOG2) ?
		2 * (FRACTION_BITS - fpe_pkg::EPS_LOG2) : 0;
	localparam logic [63:0] THRESH = 64'd1 << TSH;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_FETCH   = 9'b000000010,
		S_SQLOAD  = 9'b000000100,
		S_SQUARE  = 9'b000001000,
		S_ROOTCHK = 9'b000010000,
		S_ROOT    = 9'b000100000,
		S_DIVLOAD = 9'b001000000,
		S_DIVIDE  = 9'b010000000,
		S_EMIT    = 9'b100000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] k_q;
	logic [fpe_pkg::PLANE_W-1:0] plane_q;
	logic norm_q;
	logic [31:0] w_q;
	logic [31:0] v_q [4];
	logic [63:0] s_q;
	logic [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [NW-1:0] num_q;

	logic accept;
	logic [fpe_pkg::ADDR_W-1:0] raddr;
	logic [31:0] rdata;
	logic [1:0] j;
	logic [32:0] sum33;
	logic [31:0] sum_sat;
	logic [1:0] fetch_k;
	logic [31:0] vk_mag;
	logic [34:0] root_sh;
	logic [34:0] root_trial;
	logic root_take;
	logic [34:0] div_sh;
	logic [34:0] div_den;
	logic div_take;
	logic [NW-1:0] quot;
	logic [31:0] quot_sat;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign j = plane_q[2:1];

	// Even fetch steps read the w column, odd steps read column j.
	assign raddr = {cnt_q[2:1], (cnt_q[0] ? j : 2'd3)};
	assign fetch_k = 2'(cnt_q[3:1] - 3'd1);

	fpe_ram #(
		.WIDTH(fpe_pkg::ELEM_W),
		.DEPTH(fpe_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept),
		.waddr({outer_index, inner_index}),
		.wdata(element_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		if (plane_q[0]) begin
			sum33 = {w_q[31], w_q} - {rdata[31], rdata};
		end else begin
			sum33 = {w_q[31], w_q} + {rdata[31], rdata};
		end
		if (sum33[32] != sum33[31]) begin
			sum_sat = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sum_sat = sum33[31:0];
		end
	end

	assign vk_mag = v_q[k_q][31] ? (~v_q[k_q] + 32'd1) : v_q[k_q];

	assign root_sh = {rem_q[32:0], s_q[63:62]};
	assign root_trial = {1'b0, root_q, 2'b01};
	assign root_take = (root_sh >= root_trial);

	assign div_sh = {rem_q[33:0], num_q[NW-1]};
	assign div_den = {2'b00, root_q, 1'b0};
	assign div_take = (div_sh >= div_den);
	assign quot = {num_q[NW-2:0], div_take};

	always_comb begin
		if (v_q[k_q][31]) begin
			quot_sat = (|quot[NW-1:31]) ? 32'h8000_0000 : (~quot[31:0] + 32'd1);
		end else begin
			quot_sat = (|quot[NW-1:31]) ? 32'h7FFF_FFFF : quot[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			plane_q <= '0;
			norm_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && last_element) begin
						plane_q <= '0;
						cnt_q <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(8)) begin
						k_q <= '0;
						state_q <= S_SQLOAD;
					end
				end
				S_SQLOAD: begin
					cnt_q <= '0;
					state_q <= S_SQUARE;
				end
				S_SQUARE: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(31)) begin
						if (k_q == 2'd2) begin
							state_q <= S_ROOTCHK;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= S_SQLOAD;
						end
					end
				end
				S_ROOTCHK: begin
					cnt_q <= '0;
					if (s_q < THRESH) begin
						norm_q <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						norm_q <= 1'b1;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(31)) begin
						k_q <= '0;
						state_q <= S_DIVLOAD;
					end
				end
				S_DIVLOAD: begin
					cnt_q <= '0;
					state_q <= S_DIVIDE;
				end
				S_DIVIDE: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NW - 1)) begin
						if (k_q == 2'd3) begin
							state_q <= S_EMIT;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= S_DIVLOAD;
						end
					end
				end
				S_EMIT: begin
					cnt_q <= '0;
					if (plane_q == fpe_pkg::LAST_PLANE) begin
						state_q <= S_IDLE;
					end else begin
						plane_q <= plane_q + fpe_pkg::PLANE_W'(1);
						state_q <= S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_FETCH: begin
				if (cnt_q[0]) begin
					w_q <= rdata;
				end else if (cnt_q != '0) begin
					v_q[fetch_k] <= sum_sat;
				end
				s_q <= '0;
			end
			S_SQLOAD: begin
				mcand_q <= {32'd0, vk_mag};
				mplier_q <= vk_mag;
			end
			S_SQUARE: begin
				if (mplier_q[0]) begin
					s_q <= s_q + mcand_q;
				end
				mcand_q <= {mcand_q[62:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[31:1]};
			end
			S_ROOTCHK: begin
				rem_q <= '0;
				root_q <= '0;
			end
			S_ROOT: begin
				s_q <= {s_q[61:0], 2'b00};
				if (root_take) begin
					rem_q <= root_sh - root_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= root_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			S_DIVLOAD: begin
				rem_q <= '0;
				num_q <= ({{(NW-32){1'b0}}, vk_mag} << (FRACTION_BITS + 1)) +
					{{(NW-32){1'b0}}, root_q};
			end
			S_DIVIDE: begin
				rem_q <= div_take ? (div_sh - div_den) : div_sh;
				num_q <= quot;
				if (cnt_q == CW'(NW - 1)) begin
					v_q[k_q] <= quot_sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = (state_q == S_EMIT);
	assign plane_index = plane_q;
	assign plane_a = v_q[0];
	assign plane_b = v_q[1];
	assign plane_c = v_q[2];
	assign plane_d = v_q[3];
	assign was_normalized = norm_q;
	assign last_plane = (plane_q == fpe_pkg::LAST_PLANE);

endmodule

FILE: hdl/fpe_checker.sv
// Port-level checks for the frustum plane extraction core, with its bind.
module fpe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          last_element,
	input logic                          result_valid,
	input logic [fpe_pkg::PLANE_W-1:0]   plane_index,
	input logic                          last_plane
);

	// A result only appears inside a run.
	a_valid_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while not busy");

	// The run ends right after the sixth plane.
	a_end_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_plane) |=> !busy)
		else $error("busy after last plane");

	// A transfer marked last starts a run.
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_element) |=> busy)
		else $error("run did not start");

	// Plane index stays in range and the last mark sits on the far plane.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((plane_index <= fpe_pkg::LAST_PLANE) &&
		(last_plane == (plane_index == fpe_pkg::LAST_PLANE))))
		else $error("bad plane index");

	// Each result strobe lasts a single cycle.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

endmodule

bind frustum_plane_extract_core fpe_checker u_fpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_element (last_element),
	.result_valid (result_valid),
	.plane_index  (plane_index),
	.last_plane   (last_plane)
);

FILE: test/tb_top.sv
// Self-checking testbench for the frustum plane extraction core.
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 2000;

	typedef struct {
		logic [fpe_pkg::IDX_W-1:0] outer;
		logic [fpe_pkg::IDX_W-1:0] inner;
		logic [fpe_pkg::ELEM_W-1:0] value;
		logic last;
		logic drain;
	} load_item_t;

	typedef struct {
		logic [fpe_pkg::PLANE_W-1:0] index;
		logic signed [fpe_pkg::ELEM_W-1:0] a;
		logic signed [fpe_pkg::ELEM_W-1:0] b;
		logic signed [fpe_pkg::ELEM_W-1:0] c;
		logic signed [fpe_pkg::ELEM_W-1:0] d;
		logic normalized;
		logic last;
	} plane_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [fpe_pkg::IDX_W-1:0] outer_index;
	logic [fpe_pkg::IDX_W-1:0] inner_index;
	logic signed [fpe_pkg::ELEM_W-1:0] element_value;
	logic last_element;
	logic result_valid;
	logic [fpe_pkg::PLANE_W-1:0] plane_index;
	logic signed [fpe_pkg::ELEM_W-1:0] plane_a;
	logic signed [fpe_pkg::ELEM_W-1:0] plane_b;
	logic signed [fpe_pkg::ELEM_W-1:0] plane_c;
	logic signed [fpe_pkg::ELEM_W-1:0] plane_d;
	logic was_normalized;
	logic last_plane;

	load_item_t pending_loads[$];
	plane_t expected_planes[$];
	logic [fpe_pkg::ELEM_W-1:0] matrix_copy[fpe_pkg::DEPTH];
	logic took;
	int loads_sent;
	int total_loads;
	int loads_taken;
	int planes_seen;
	int flat_planes;
	int mismatches;
	int idle_cycles;
	bit timed_out;

	frustum_plane_extract_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.outer_index(outer_index), .inner_index(inner_index),
		.element_value(element_value), .last_element(last_element),
		.result_valid(result_valid), .plane_index(plane_index),
		.plane_a(plane_a), .plane_b(plane_b), .plane_c(plane_c), .plane_d(plane_d),
		.was_normalized(was_normalized), .last_plane(last_plane)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [fpe_pkg::ELEM_W-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[fpe_pkg::ELEM_W-1:0];
	endfunction

	function automatic longint unsigned int_root(input longint unsigned s);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s = s - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Divide by the length with rounding of the magnitude, ties away from zero.
	function automatic logic signed [fpe_pkg::ELEM_W-1:0] scale_by_length(
		input logic signed [fpe_pkg::ELEM_W-1:0] x, input longint unsigned len);
		longint unsigned mag;
		longint unsigned q;
		longint neg_q;
		mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
		q = ((mag << fpe_pkg::FRACTION_BITS) * 2 + len) / (2 * len);
		neg_q = -longint'(q);
		if (x < 0)
			return (q >= 64'h80000000) ? 32'sh80000000 : neg_q[fpe_pkg::ELEM_W-1:0];
		return (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[fpe_pkg::ELEM_W-1:0];
	endfunction

	task automatic extract_planes();
		longint unsigned flat_limit;
		longint unsigned sq;
		longint unsigned len;
		longint w;
		longint m;
		longint t;
		logic signed [fpe_pkg::ELEM_W-1:0] v[4];
		plane_t pl;
		flat_limit = (fpe_pkg::FRACTION_BITS > fpe_pkg::EPS_LOG2) ?
			(64'd1 << (2 * (fpe_pkg::FRACTION_BITS - fpe_pkg::EPS_LOG2))) : 1;
		for (int p = 0; p < 6; p++) begin
			sq = 0;
			for (int k = 0; k < 4; k++) begin
				w = longint'($signed(matrix_copy[k * 4 + 3]));
				m = longint'($signed(matrix_copy[k * 4 + p / 2]));
				v[k] = clamp32((p % 2 == 1) ? w - m : w + m);
			end
			for (int k = 0; k < 3; k++) begin
				t = longint'(v[k]);
				sq = sq + longint'(t * t);
			end
			pl.normalized = (sq >= flat_limit);
			if (pl.normalized) begin
				len = int_root(sq);
				for (int k = 0; k < 4; k++)
					v[k] = scale_by_length(v[k], len);
			end
			pl.index = p[fpe_pkg::PLANE_W-1:0];
			pl.a = v[0];
			pl.b = v[1];
			pl.c = v[2];
			pl.d = v[3];
			pl.last = (pl.index == fpe_pkg::LAST_PLANE);
			expected_planes.push_back(pl);
		end
	endtask

	// Acceptance, prediction and result checking, all on the rising edge.
	always @(posedge clk or negedge arst_n) begin
		plane_t exp_pl;
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (result_valid) begin
				planes_seen++;
				if (!was_normalized)
					flat_planes++;
				if (expected_planes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected plane %0d at %0t", plane_index, $realtime);
				end else begin
					exp_pl = expected_planes.pop_front();
					if (plane_index !== exp_pl.index || plane_a !== exp_pl.a
						|| plane_b !== exp_pl.b || plane_c !== exp_pl.c
						|| plane_d !== exp_pl.d || was_normalized !== exp_pl.normalized
						|| last_plane !== exp_pl.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: plane mismatch at %0t", $realtime);
							$display("  expected idx %0d a %h b %h c %h d %h norm %b last %b",
								exp_pl.index, exp_pl.a, exp_pl.b, exp_pl.c, exp_pl.d,
								exp_pl.normalized, exp_pl.last);
							$display("  actual   idx %0d a %h b %h c %h d %h norm %b last %b",
								plane_index, plane_a, plane_b, plane_c, plane_d,
								was_normalized, last_plane);
						end
					end
				end
			end
			if (start && !busy) begin
				loads_taken++;
				matrix_copy[{outer_index, inner_index}] = element_value;
				if (last_element)
					extract_planes();
			end
		end
	end

	// Driver: a new item goes out on the falling edge once the last one was taken.
	always @(negedge clk) begin
		load_item_t it;
		int idle_pct;
		logic next_start;
		if (arst_n && (!start || took)) begin
			next_start = 1'b0;
			idle_pct = (loads_sent < total_loads / 3) ? 7 :
				(loads_sent < 2 * total_loads / 3) ? 66 : 0;
			if (pending_loads.size() != 0) begin
				if (pending_loads[0].drain) begin
					if (expected_planes.size() == 0 && !busy)
						void'(pending_loads.pop_front());
				end else if ($urandom_range(99) >= idle_pct) begin
					it = pending_loads.pop_front();
					loads_sent++;
					next_start = 1'b1;
					outer_index <= it.outer;
					inner_index <= it.inner;
					element_value <= it.value;
					last_element <= it.last;
				end
			end
			start <= next_start;
		end
	end

	// Watchdog on cycles with no transfer in either direction.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [fpe_pkg::ELEM_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 20) begin
			case ($urandom_range(4))
				0: return 32'h7FFFFFFF;
				1: return 32'h80000000;
				2: return 32'h00000000;
				3: return 32'hFFFFFFFF;
				default: return 32'h00010000;
			endcase
		end
		if (sel < 60)
			return $urandom_range(32'h0003FFFF) - 32'h00020000;
		return $urandom();
	endfunction

	task automatic queue_load(input int o, input int i,
		input logic [fpe_pkg::ELEM_W-1:0] v, input logic lst);
		load_item_t it;
		it.outer = o[fpe_pkg::IDX_W-1:0];
		it.inner = i[fpe_pkg::IDX_W-1:0];
		it.value = v;
		it.last = lst;
		it.drain = 1'b0;
		pending_loads.push_back(it);
		total_loads++;
	endtask

	task automatic queue_full_matrix();
		int order[16];
		int j;
		int tmp;
		for (int n = 0; n < 16; n++)
			order[n] = n;
		for (int n = 15; n > 0; n--) begin
			j = $urandom_range(n);
			tmp = order[n];
			order[n] = order[j];
			order[j] = tmp;
		end
		for (int n = 0; n < 16; n++)
			queue_load(order[n] / 4, order[n] % 4, pick_value(), n == 15);
	endtask

	initial begin
		load_item_t marker;
		int burst;
		arst_n = 1'b0;
		start = 1'b0;
		outer_index = '0;
		inner_index = '0;
		element_value = '0;
		last_element = 1'b0;
		total_loads = 0;
		timed_out = 1'b0;
		mismatches = 0;
		// Directed: a full matrix of extremes that forces saturated sums.
		for (int n = 0; n < 16; n++) begin
			queue_load(n / 4, n % 4,
				(n % 4 == 3) ? ((n / 4) % 2 == 0 ? 32'h7FFFFFFF : 32'h80000000) :
				(n % 2 == 0) ? 32'h7FFFFFFF : 32'h80000000, n == 15);
		end
		// Directed: left plane has zero length when column 0 cancels column 3.
		queue_load(1, 3, 32'h7FFFFFFF, 1'b0);
		queue_load(0, 0, 32'h80000001, 1'b0);
		queue_load(1, 0, 32'h80000001, 1'b0);
		queue_load(2, 0, 32'h80000001, 1'b1);
		queue_load(3, 2, 32'h00010000, 1'b1);
		marker.drain = 1'b1;
		pending_loads.push_back(marker);
		while (total_loads < 430) begin
			if ($urandom_range(99) < 55) begin
				queue_full_matrix();
			end else begin
				burst = $urandom_range(6);
				for (int n = 0; n < burst; n++)
					queue_load($urandom_range(3), $urandom_range(3), pick_value(), 1'b0);
				queue_load($urandom_range(3), $urandom_range(3), pick_value(), 1'b1);
			end
			if (total_loads > 200 && total_loads < 230)
				pending_loads.push_back(marker);
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_loads.size() == 0 && !start && expected_planes.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Loaded %0d matrix elements; checked %0d planes, %0d of them unnormalized.",
			loads_taken, planes_seen, flat_planes);
		if (mismatches == 0 && expected_planes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: frustum_plane_extract_core.f
hdl/fpe_pkg.sv
hdl/fpe_ram.sv
hdl/frustum_plane_extract_core.sv
hdl/fpe_checker.sv
test/tb_top.sv
